[rtl/rrts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared widths, reset values and the cell control struct of the
// round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int QUANT_W = 8;

  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(4);

  typedef struct packed {
    logic               en;
    logic               shift;
    logic               dec_front;
    logic               rot_en;
    logic               arr_en;
    logic [ID_W-1:0]    front_id;
    logic [BURST_W-1:0] rem_dec;
    logic [ID_W-1:0]    arr_id;
    logic [BURST_W-1:0] arr_burst;
  } cell_ctl_t;

endpackage

[rtl/rrts_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_if
// Channel interfaces of the scheduler: tick input, result output and the
// quantum write port.
// ----------------------------------------------------------------------------
interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic        arrive_valid;
  logic [7:0]  arrive_id;
  logic [15:0] arrive_burst;

  modport source (output valid, arrive_valid, arrive_id, arrive_burst, input ready);
  modport sink   (input valid, arrive_valid, arrive_id, arrive_burst, output ready);
endinterface

interface rrts_out_if #(
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic             done_valid;
  logic [7:0]       done_id;
  logic             running_valid;
  logic [7:0]       running_id;
  logic [CNT_W-1:0] queue_count;
  logic             dropped;

  modport source (output valid, done_valid, done_id, running_valid, running_id,
                  queue_count, dropped, input ready);
  modport sink   (input valid, done_valid, done_id, running_valid, running_id,
                  queue_count, dropped, output ready);
endinterface

interface rrts_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] quantum;

  modport source (output valid, quantum, input ready);
  modport sink   (input valid, quantum, output ready);
endinterface

[rtl/rrts_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_cell
// One queue slot. Takes its neighbor's job on a shift, as front slot the
// decremented burst, and the rotated job or an arrival at its position.
// ----------------------------------------------------------------------------
module rrts_cell #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX         = 0
) (
  input  logic                          clk,
  input  rrts_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rot_pos,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] arr_pos,
  input  logic [rrts_pkg::ID_W-1:0]     nb_id,
  input  logic [rrts_pkg::BURST_W-1:0]  nb_rem,
  output logic [rrts_pkg::ID_W-1:0]     id_r,
  output logic [rrts_pkg::BURST_W-1:0]  rem_r,
  output logic [rrts_pkg::ID_W-1:0]     id_nxt
);
  import rrts_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(IDX);

  logic [BURST_W-1:0] rem_nxt;

  always_comb begin
    id_nxt  = id_r;
    rem_nxt = rem_r;
    if (ctl.shift) begin
      id_nxt  = nb_id;
      rem_nxt = nb_rem;
    end
    if (ctl.dec_front && (IDX == 0)) begin
      rem_nxt = ctl.rem_dec;
    end
    if (ctl.rot_en && (rot_pos == MY_POS)) begin
      id_nxt  = ctl.front_id;
      rem_nxt = ctl.rem_dec;
    end
    if (ctl.arr_en && (arr_pos == MY_POS)) begin
      id_nxt  = ctl.arr_id;
      rem_nxt = ctl.arr_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      id_r  <= id_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

[rtl/rrts_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl
// Tick control: services the front job, decides finish, rotation and
// arrival, keeps the count and slice counter, and registers the result.
// ----------------------------------------------------------------------------
module rrts_ctrl #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rrts_in_if.sink                        in_bus,
  rrts_out_if.source                     out_bus,
  rrts_cfg_if.sink                       cfg_bus,
  input  logic [rrts_pkg::ID_W-1:0]      front_id,
  input  logic [rrts_pkg::BURST_W-1:0]   front_rem,
  input  logic [rrts_pkg::ID_W-1:0]      head_id_nxt,
  output rrts_pkg::cell_ctl_t            ctl,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rot_pos,
  output logic [$clog2(QUEUE_DEPTH)-1:0] arr_pos
);
  import rrts_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0]   occ_r, occ_nxt, occ_pop;
  logic [QUANT_W-1:0] slice_r, slice_nxt;
  logic [QUANT_W-1:0] quantum_r;
  logic [QUANT_W:0]   slice_inc;
  logic               out_valid_r;
  logic               accept;
  logic               busy, fin, rot, arr_ok, drop;
  logic [BURST_W-1:0] rem_dec;

  logic               done_valid_r, running_valid_r, dropped_r;
  logic [ID_W-1:0]    done_id_r, running_id_r;
  logic [CNT_W-1:0]   count_r;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign accept        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  assign busy      = (occ_r != '0);
  assign rem_dec   = (front_rem == '0) ? '0 : front_rem - BURST_W'(1);
  assign fin       = busy && (rem_dec == '0);
  assign slice_inc = {1'b0, slice_r} + (QUANT_W+1)'(1);
  assign rot       = busy && !fin && (slice_inc >= {1'b0, quantum_r});
  assign occ_pop   = occ_r - CNT_W'(fin);
  assign arr_ok    = in_bus.arrive_valid && (occ_pop < DEPTH_C);
  assign drop      = in_bus.arrive_valid && !arr_ok;
  assign occ_nxt   = occ_pop + CNT_W'(arr_ok);
  assign slice_nxt = !busy ? slice_r : ((fin || rot) ? '0 : slice_inc[QUANT_W-1:0]);

  assign rot_pos = IDX_W'(occ_r - CNT_W'(1));
  assign arr_pos = IDX_W'(occ_pop);

  always_comb begin
    ctl           = '0;
    ctl.en        = accept;
    ctl.shift     = fin || rot;
    ctl.dec_front = busy && !fin && !rot;
    ctl.rot_en    = rot;
    ctl.arr_en    = arr_ok;
    ctl.front_id  = front_id;
    ctl.rem_dec   = rem_dec;
    ctl.arr_id    = in_bus.arrive_id;
    ctl.arr_burst = in_bus.arrive_burst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      slice_r     <= '0;
      quantum_r   <= QUANT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        quantum_r <= cfg_bus.quantum;
      end
      if (accept) begin
        occ_r       <= occ_nxt;
        slice_r     <= slice_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      done_valid_r    <= fin;
      done_id_r       <= fin ? front_id : '0;
      running_valid_r <= (occ_nxt != '0);
      running_id_r    <= (occ_nxt != '0) ? head_id_nxt : '0;
      count_r         <= occ_nxt;
      dropped_r       <= drop;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.done_valid    = done_valid_r;
  assign out_bus.done_id       = done_id_r;
  assign out_bus.running_valid = running_valid_r;
  assign out_bus.running_id    = running_id_r;
  assign out_bus.queue_count   = count_r;
  assign out_bus.dropped       = dropped_r;

endmodule

[rtl/round_robin_time_slice_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Round-robin scheduler with a time quantum, built as a row of job cells.
//
//   Channel   Dir   Beat
//   in_bus    in    one scheduler tick with an optional arriving job
//   out_bus   out   one result per tick: done job, running job, count, drop
//   cfg_bus   in    write of the quantum register
//
// A tick is accepted when valid meets ready, and its result appears in the output
// register on the next cycle; a new tick can be taken every cycle while the output is not stalled.
// The cell row is updated on the same edge that accepts the tick, and it shifts
// toward the front on a finish or a rotation.
// Reset empties the queue, clears the slice counter and sets the quantum to 4.
// A stalled result holds in the output register and blocks further ticks.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rrts_in_if.sink    in_bus,
  rrts_out_if.source out_bus,
  rrts_cfg_if.sink   cfg_bus
);
  import rrts_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  cell_ctl_t          ctl;
  logic [IDX_W-1:0]   rot_pos, arr_pos;
  logic [ID_W-1:0]    cell_id  [QUEUE_DEPTH+1];
  logic [BURST_W-1:0] cell_rem [QUEUE_DEPTH+1];
  logic [ID_W-1:0]    cell_id_nxt [QUEUE_DEPTH];

  assign cell_id[QUEUE_DEPTH]  = '0;
  assign cell_rem[QUEUE_DEPTH] = '0;

  rrts_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_bus     (cfg_bus),
    .front_id    (cell_id[0]),
    .front_rem   (cell_rem[0]),
    .head_id_nxt (cell_id_nxt[0]),
    .ctl         (ctl),
    .rot_pos     (rot_pos),
    .arr_pos     (arr_pos)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rrts_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .rot_pos (rot_pos),
      .arr_pos (arr_pos),
      .nb_id   (cell_id[i+1]),
      .nb_rem  (cell_rem[i+1]),
      .id_r    (cell_id[i]),
      .rem_r   (cell_rem[i]),
      .id_nxt  (cell_id_nxt[i])
    );
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin time-slice scheduler. A driver
// sends scheduler ticks in random bursts, a monitor takes the result beats
// under a stalling receiver, and an in-bench scheduler model predicts each
// result. The run starts with a directed sequence and then goes through
// random phases at several quantum settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
  import rrts_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CNT_W       = 5;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic               arrive_valid;
    logic [ID_W-1:0]    arrive_id;
    logic [BURST_W-1:0] arrive_burst;
  } tick_t;

  typedef struct packed {
    logic             done_valid;
    logic [ID_W-1:0]  done_id;
    logic             running_valid;
    logic [ID_W-1:0]  running_id;
    logic [CNT_W-1:0] queue_count;
    logic             dropped;
  } sched_result_t;

  typedef enum int {READY_ALWAYS, READY_PATTERN, READY_RANDOM} stall_mode_t;

  logic clk;
  logic rst_n;

  rrts_in_if                   in_bus ();
  rrts_out_if #(.CNT_W(CNT_W)) out_bus ();
  rrts_cfg_if                  cfg_bus ();

  round_robin_time_slice_scheduler #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  tick_t         tick_q[$];
  sched_result_t expected_q[$];
  int            ticks_queued;
  int            ticks_taken;
  int            error_count;
  int            idle_cycles;
  logic          in_fired;

  logic [ID_W-1:0]    job_id   [DEPTH];
  logic [BURST_W-1:0] job_left [DEPTH];
  int                 q_head;
  int                 q_tail;
  int                 q_occ;
  int                 slice_cnt;
  logic [QUANT_W-1:0] quantum_now;

  int          burst_left;
  int          gap_left;
  stall_mode_t stall_mode;
  int          mode_left;
  int          pattern_pos;
  logic [7:0]  ready_pattern;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic sched_result_t schedule_tick(tick_t t);
    sched_result_t      r;
    logic [BURST_W-1:0] left;
    int                 h;
    r = '0;
    if (q_occ > 0) begin
      h    = q_head;
      left = job_left[h];
      if (left != '0) left = left - BURST_W'(1);
      job_left[h] = left;
      if (left == '0) begin
        r.done_valid = 1'b1;
        r.done_id    = job_id[h];
        q_head       = (h + 1) % DEPTH;
        q_occ        = q_occ - 1;
        slice_cnt    = 0;
      end else begin
        slice_cnt = slice_cnt + 1;
        if (slice_cnt >= int'(quantum_now)) begin
          job_id[q_tail]   = job_id[h];
          job_left[q_tail] = left;
          q_head           = (h + 1) % DEPTH;
          q_tail           = (q_tail + 1) % DEPTH;
          slice_cnt        = 0;
        end
      end
    end
    if (t.arrive_valid) begin
      if (q_occ < DEPTH) begin
        job_id[q_tail]   = t.arrive_id;
        job_left[q_tail] = t.arrive_burst;
        q_tail           = (q_tail + 1) % DEPTH;
        q_occ            = q_occ + 1;
      end else begin
        r.dropped = 1'b1;
      end
    end
    if (q_occ > 0) begin
      r.running_valid = 1'b1;
      r.running_id    = job_id[q_head];
    end
    r.queue_count = CNT_W'(q_occ);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    sched_result_t want;
    tick_t         t;
    if (!rst_n) begin
      in_fired    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fired <= in_bus.valid && in_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) quantum_now = cfg_bus.quantum;
      if (out_bus.valid && out_bus.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat arrived with no tick outstanding");
          error_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("done_valid", 16'(want.done_valid), 16'(out_bus.done_valid));
          check_field("done_id", 16'(want.done_id), 16'(out_bus.done_id));
          check_field("running_valid", 16'(want.running_valid),
                      16'(out_bus.running_valid));
          check_field("running_id", 16'(want.running_id), 16'(out_bus.running_id));
          check_field("queue_count", 16'(want.queue_count), 16'(out_bus.queue_count));
          check_field("dropped", 16'(want.dropped), 16'(out_bus.dropped));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        t.arrive_valid = in_bus.arrive_valid;
        t.arrive_id    = in_bus.arrive_id;
        t.arrive_burst = in_bus.arrive_burst;
        expected_q.push_back(schedule_tick(t));
        ticks_taken++;
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin : driver
    tick_t t;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fired) begin
      if (gap_left > 0 || tick_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_bus.valid        <= 1'b0;
        in_bus.arrive_valid <= 1'($urandom);
        in_bus.arrive_id    <= ID_W'($urandom);
        in_bus.arrive_burst <= BURST_W'($urandom);
      end else begin
        t = tick_q.pop_front();
        in_bus.valid        <= 1'b1;
        in_bus.arrive_valid <= t.arrive_valid;
        in_bus.arrive_id    <= t.arrive_id;
        in_bus.arrive_burst <= t.arrive_burst;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (mode_left == 0) begin
      stall_mode    = stall_mode_t'($urandom_range(0, 2));
      ready_pattern = 8'($urandom) | 8'h01;
      mode_left     = $urandom_range(20, 80);
    end
    mode_left--;
    pattern_pos = (pattern_pos + 1) % 8;
    case (stall_mode)
      READY_ALWAYS:  out_bus.ready <= 1'b1;
      READY_PATTERN: out_bus.ready <= ready_pattern[pattern_pos];
      default:       out_bus.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic queue_tick(logic av, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
    tick_t t;
    t.arrive_valid = av;
    t.arrive_id    = id;
    t.arrive_burst = burst;
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (ticks_taken != ticks_queued || expected_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_quantum(logic [QUANT_W-1:0] q);
    @(negedge clk);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.quantum <= q;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid   <= 1'b0;
    cfg_bus.quantum <= QUANT_W'($urandom);
  endtask

  task automatic run_phase(logic [QUANT_W-1:0] q, int n_ticks, int arrive_pct);
    logic [BURST_W-1:0] burst;
    int                 pick;
    write_quantum(q);
    repeat (n_ticks) begin
      pick = $urandom_range(0, 127);
      if (pick == 0) begin
        burst = BURST_W'($urandom);
      end else if (pick < 4) begin
        burst = '0;
      end else begin
        burst = BURST_W'($urandom_range(1, 24));
      end
      queue_tick($urandom_range(0, 99) < arrive_pct, ID_W'($urandom), burst);
    end
    wait_idle();
  endtask

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.arrive_valid = 1'b0;
    in_bus.arrive_id    = '0;
    in_bus.arrive_burst = '0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.quantum     = '0;
    ticks_queued        = 0;
    ticks_taken         = 0;
    error_count         = 0;
    idle_cycles         = 0;
    in_fired            = 1'b0;
    q_head              = 0;
    q_tail              = 0;
    q_occ               = 0;
    slice_cnt           = 0;
    quantum_now         = QUANT_RESET;
    burst_left          = 1;
    gap_left            = 0;
    stall_mode          = READY_ALWAYS;
    mode_left           = 0;
    pattern_pos         = 0;
    ready_pattern       = 8'hFF;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Idle tick on an empty queue, a one-tick job, a zero-burst job, then a
    // lone job that rotates back onto itself at the end of its slice.
    queue_tick(1'b0, 8'hFF, 16'hFFFF);
    queue_tick(1'b1, 8'h00, 16'd1);
    queue_tick(1'b1, 8'hFF, 16'd0);
    queue_tick(1'b1, 8'hA5, 16'd5);
    repeat (4) queue_tick(1'b0, 8'h00, 16'h0000);
    // The first arrival lands on the tick that finishes the lone job; the
    // queue then fills and one more arrival is dropped.
    for (int i = 0; i < DEPTH; i++) queue_tick(1'b1, ID_W'(8'h10 + i), 16'd20);
    queue_tick(1'b1, 8'h5A, 16'hFFFF);
    wait_idle();

    run_phase(8'd255, 150, 30);
    run_phase(8'd1, 150, 60);
    run_phase(8'd0, 80, 40);
    run_phase(8'd2, 150, 90);
    run_phase(8'd7, 150, 20);
    run_phase(8'd3, 120, 50);

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
